// File: rtl/core/bfr_pkg.sv
package bfr_pkg;

  localparam int BYTE_W          = 8;
  localparam int ID_W            = 16;
  localparam int LEN_W           = 6;
  localparam int POS_W           = 6;
  localparam int MAX_RESULTS     = 32;
  localparam int CHECK_BYTES     = 2;
  localparam int DEF_MAX_PAYLOAD = 32;

  localparam int CFG_AW = 4;
  localparam int CFG_DW = 32;

  localparam logic [BYTE_W-1:0] START_BYTE_RST = 8'd126;
  localparam logic [BYTE_W-1:0] END_BYTE_RST   = 8'd127;
  localparam logic [LEN_W-1:0]  MAX_LENGTH_RST = 6'd32;

  // register index, taken from paddr[3:2]
  localparam logic [1:0] REG_START_BYTE = 2'd0;
  localparam logic [1:0] REG_END_BYTE   = 2'd1;
  localparam logic [1:0] REG_MAX_LENGTH = 2'd2;

  localparam logic OP_BYTE  = 1'b0;
  localparam logic OP_FETCH = 1'b1;

  typedef struct packed {
    logic [BYTE_W-1:0] start_byte;
    logic [BYTE_W-1:0] end_byte;
    logic [LEN_W-1:0]  max_length;
  } cfg_t;

  typedef struct packed {
    logic pos_clr;
    logic pos_inc;
    logic id_lo_ld;
    logic id_hi_ld;
    logic len_ld;
    logic pay_wr;
    logic k_clr;
    logic rd_issue;
    logic empty_ld;
    logic empty_avail;
  } dp_cmd_t;

  typedef struct packed {
    logic start_hit;
    logic end_hit;
    logic len_over;
    logic rx_zero;
    logic pos_zero;
    logic pay_done;
    logic chk_done;
    logic len_zero;
    logic last_q;
  } dp_stat_t;

endpackage

// File: rtl/core/bfr_in_if.sv
interface bfr_in_if import bfr_pkg::*;;
  logic              valid;
  logic              ready;
  logic              op;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output op, output rx_byte, input ready);
  modport sink   (input valid, input op, input rx_byte, output ready);
endinterface

// File: rtl/core/bfr_out_if.sv
interface bfr_out_if import bfr_pkg::*;;
  logic              valid;
  logic              ready;
  logic              available;
  logic [ID_W-1:0]   frame_ident;
  logic [LEN_W-1:0]  frame_length;
  logic              has_data;
  logic [BYTE_W-1:0] data_byte;
  logic              last;

  modport source (output valid, output available, output frame_ident, output frame_length,
                  output has_data, output data_byte, output last, input ready);
  modport sink   (input valid, input available, input frame_ident, input frame_length,
                  input has_data, input data_byte, input last, output ready);
endinterface

// File: rtl/core/byte_frame_receiver_core.sv
// Serial frame receiver: bytes (op 0) are parsed as start byte, 16-bit id low byte first,
// length, payload, two check bytes and end byte; a good end byte marks the frame ready.
// A fetch (op 0 is a byte, op 1 a fetch) returns one beat per payload byte, or a single
// beat when nothing is ready or the frame has no payload. A byte item is taken whenever
// no fetch is in progress. A fetch holds off new items until its last beat is taken: after
// its accept, each payload beat is a payload buffer read, then the output beat, held by any
// out_chan stall; a single beat fetch goes from its accept straight to the output beat,
// held by any stall. The payload buffer comes out of reset cleared through per-entry valid
// bits, so no clearing pass is needed.
module byte_frame_receiver_core import bfr_pkg::*; #(
  parameter int MAX_PAYLOAD = DEF_MAX_PAYLOAD
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0] cfg_prdata,
  output logic              cfg_pready,
  bfr_in_if.sink            in_chan,
  bfr_out_if.source         out_chan
);

  cfg_t     cfg;
  dp_cmd_t  cmd;
  dp_stat_t stat;

  bfr_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  bfr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_op     (in_chan.op),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  bfr_dpath #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_dpath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg),
    .rx_byte      (in_chan.rx_byte),
    .cmd          (cmd),
    .stat         (stat),
    .available    (out_chan.available),
    .frame_ident  (out_chan.frame_ident),
    .frame_length (out_chan.frame_length),
    .has_data     (out_chan.has_data),
    .data_byte    (out_chan.data_byte),
    .last         (out_chan.last)
  );

endmodule

// File: rtl/core/bfr_cfg_regs.sv
module bfr_cfg_regs import bfr_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  cfg_t       cfg_r;
  cfg_t       cfg_nxt;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[3:2];
  assign cfg     = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (reg_idx)
        REG_START_BYTE: cfg_nxt.start_byte = pwdata[BYTE_W-1:0];
        REG_END_BYTE:   cfg_nxt.end_byte   = pwdata[BYTE_W-1:0];
        REG_MAX_LENGTH: cfg_nxt.max_length = pwdata[LEN_W-1:0];
        default:        cfg_nxt            = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_START_BYTE: prdata = {{(CFG_DW-BYTE_W){1'b0}}, cfg_r.start_byte};
      REG_END_BYTE:   prdata = {{(CFG_DW-BYTE_W){1'b0}}, cfg_r.end_byte};
      REG_MAX_LENGTH: prdata = {{(CFG_DW-LEN_W){1'b0}}, cfg_r.max_length};
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_byte <= START_BYTE_RST;
      cfg_r.end_byte   <= END_BYTE_RST;
      cfg_r.max_length <= MAX_LENGTH_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// File: rtl/core/bfr_ctrl.sv
module bfr_ctrl import bfr_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_op,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  typedef enum logic [5:0] {
    PH_HUNT    = 6'b000001,
    PH_IDENT   = 6'b000010,
    PH_LENGTH  = 6'b000100,
    PH_PAYLOAD = 6'b001000,
    PH_CHECK   = 6'b010000,
    PH_END     = 6'b100000
  } phase_t;

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_READ = 3'b010,
    F_EMIT = 3'b100
  } fetch_t;

  phase_t ph_r, ph_nxt;
  fetch_t fs_r, fs_nxt;
  logic   ready_r, ready_nxt;
  logic   acc;

  assign in_ready  = (fs_r == F_IDLE);
  assign out_valid = (fs_r == F_EMIT);
  assign acc       = in_valid & in_ready;

  always_comb begin
    ph_nxt    = ph_r;
    fs_nxt    = fs_r;
    ready_nxt = ready_r;
    cmd       = '0;

    if (acc && in_op == OP_BYTE) begin
      unique case (ph_r)
        PH_HUNT: begin
          if (stat.start_hit) begin
            ph_nxt      = PH_IDENT;
            cmd.pos_clr = 1'b1;
          end
        end
        PH_IDENT: begin
          if (stat.pos_zero) begin
            cmd.id_lo_ld = 1'b1;
            cmd.pos_inc  = 1'b1;
          end else begin
            cmd.id_hi_ld = 1'b1;
            cmd.pos_clr  = 1'b1;
            ph_nxt       = PH_LENGTH;
          end
        end
        PH_LENGTH: begin
          if (stat.len_over) begin
            ph_nxt = PH_HUNT;
          end else begin
            cmd.len_ld  = 1'b1;
            cmd.pos_clr = 1'b1;
            ph_nxt      = stat.rx_zero ? PH_CHECK : PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          cmd.pay_wr = 1'b1;
          if (stat.pay_done) begin
            cmd.pos_clr = 1'b1;
            ph_nxt      = PH_CHECK;
          end else begin
            cmd.pos_inc = 1'b1;
          end
        end
        PH_CHECK: begin
          if (stat.chk_done) begin
            cmd.pos_clr = 1'b1;
            ph_nxt      = PH_END;
          end else begin
            cmd.pos_inc = 1'b1;
          end
        end
        PH_END: begin
          if (stat.end_hit) ready_nxt = 1'b1;
          ph_nxt = PH_HUNT;
        end
        default: ph_nxt = PH_HUNT;
      endcase
    end

    unique case (fs_r)
      F_IDLE: begin
        if (acc && in_op == OP_FETCH) begin
          ready_nxt = 1'b0;
          // nothing ready, or a frame without payload: a single beat
          if (!ready_r || stat.len_zero) begin
            cmd.empty_ld    = 1'b1;
            cmd.empty_avail = ready_r;
            fs_nxt          = F_EMIT;
          end else begin
            cmd.k_clr = 1'b1;
            fs_nxt    = F_READ;
          end
        end
      end
      F_READ: begin
        cmd.rd_issue = 1'b1;
        fs_nxt       = F_EMIT;
      end
      F_EMIT: begin
        if (out_ready) fs_nxt = stat.last_q ? F_IDLE : F_READ;
      end
      default: fs_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r    <= PH_HUNT;
      fs_r    <= F_IDLE;
      ready_r <= 1'b0;
    end else begin
      ph_r    <= ph_nxt;
      fs_r    <= fs_nxt;
      ready_r <= ready_nxt;
    end
  end

endmodule

// File: rtl/core/bfr_dpath.sv
module bfr_dpath import bfr_pkg::*; #(
  parameter int MAX_PAYLOAD = DEF_MAX_PAYLOAD
) (
  input  logic              clk,
  input  logic              rst_n,
  input  cfg_t              cfg,
  input  logic [BYTE_W-1:0] rx_byte,
  input  dp_cmd_t           cmd,
  output dp_stat_t          stat,
  output logic              available,
  output logic [ID_W-1:0]   frame_ident,
  output logic [LEN_W-1:0]  frame_length,
  output logic              has_data,
  output logic [BYTE_W-1:0] data_byte,
  output logic              last
);

  localparam int                AW      = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam logic [BYTE_W-1:0] MAXP_B  = BYTE_W'(MAX_PAYLOAD);
  localparam logic [POS_W:0]    MAXP_P  = (POS_W+1)'(MAX_PAYLOAD);
  localparam logic [LEN_W-1:0]  MAXRES  = LEN_W'(MAX_RESULTS);
  localparam logic [POS_W-1:0]  CHK_CNT = POS_W'(CHECK_BYTES);

  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [ID_W-1:0]   ident_r;
  logic [LEN_W-1:0]  len_r;
  logic [POS_W-1:0]  k_r, k_nxt;
  logic [BYTE_W-1:0] mem [MAX_PAYLOAD];
  logic [MAX_PAYLOAD-1:0] vld_r;
  logic [BYTE_W-1:0] rd_q_r;
  logic              avail_r, has_data_r, last_r;

  logic [POS_W-1:0]  pos_inc;
  logic [POS_W-1:0]  k_inc;
  logic [BYTE_W-1:0] limit;
  logic [BYTE_W-1:0] max_len_b;
  logic [LEN_W-1:0]  n_res;
  logic              wr_ok;
  logic [AW-1:0]     wr_addr, rd_addr;

  assign pos_inc   = pos_r + POS_W'(1);
  assign k_inc     = k_r + POS_W'(1);
  assign max_len_b = {{(BYTE_W-LEN_W){1'b0}}, cfg.max_length};
  assign limit     = (max_len_b < MAXP_B) ? max_len_b : MAXP_B;
  assign n_res     = (len_r > MAXRES) ? MAXRES : len_r;
  assign wr_ok     = {1'b0, pos_r} < MAXP_P;
  assign wr_addr   = pos_r[AW-1:0];
  assign rd_addr   = k_r[AW-1:0];

  assign stat.start_hit = (rx_byte == cfg.start_byte);
  assign stat.end_hit   = (rx_byte == cfg.end_byte);
  assign stat.len_over  = (rx_byte > limit);
  assign stat.rx_zero   = (rx_byte == '0);
  assign stat.pos_zero  = (pos_r == '0);
  assign stat.pay_done  = (pos_inc >= len_r);
  assign stat.chk_done  = (pos_inc >= CHK_CNT);
  assign stat.len_zero  = (len_r == '0);
  assign stat.last_q    = last_r;

  always_comb begin
    pos_nxt = pos_r;
    if (cmd.pos_clr)      pos_nxt = '0;
    else if (cmd.pos_inc) pos_nxt = pos_inc;
    k_nxt = k_r;
    if (cmd.k_clr)         k_nxt = '0;
    else if (cmd.rd_issue) k_nxt = k_inc;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      ident_r <= '0;
      len_r   <= '0;
      k_r     <= '0;
      vld_r   <= '0;
    end else begin
      pos_r <= pos_nxt;
      k_r   <= k_nxt;
      if (cmd.id_lo_ld) ident_r[7:0]  <= rx_byte;
      if (cmd.id_hi_ld) ident_r[15:8] <= rx_byte;
      if (cmd.len_ld)   len_r         <= rx_byte[LEN_W-1:0];
      if (cmd.pay_wr && wr_ok) vld_r[wr_addr] <= 1'b1;
    end
  end

  // payload buffer; entries never written read as zero through vld_r
  always_ff @(posedge clk) begin
    if (cmd.pay_wr && wr_ok) mem[wr_addr] <= rx_byte;
    if (cmd.rd_issue) rd_q_r <= vld_r[rd_addr] ? mem[rd_addr] : '0;
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_issue) begin
      avail_r    <= 1'b1;
      has_data_r <= 1'b1;
      last_r     <= (k_inc == n_res);
    end else if (cmd.empty_ld) begin
      avail_r    <= cmd.empty_avail;
      has_data_r <= 1'b0;
      last_r     <= 1'b1;
    end
  end

  assign available    = avail_r;
  assign frame_ident  = avail_r ? ident_r : '0;
  assign frame_length = avail_r ? len_r : '0;
  assign has_data     = has_data_r;
  assign data_byte    = has_data_r ? rd_q_r : '0;
  assign last         = last_r;

endmodule

// File: test/tb_top.sv
module tb_top;
  import bfr_pkg::*;

  localparam int PAYLOAD_CAP  = DEF_MAX_PAYLOAD;
  localparam int RANDOM_ITEMS = 100;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 20;
  localparam int IDLE_PCT     = 33;

  typedef enum logic [2:0] {
    HUNT_SOF, GET_IDENT, GET_LENGTH, GET_PAYLOAD, GET_CHECK, GET_EOF
  } rx_phase_e;

  typedef struct packed {
    logic              available;
    logic [ID_W-1:0]   ident;
    logic [LEN_W-1:0]  length;
    logic              has_data;
    logic [BYTE_W-1:0] data;
    logic              last;
  } frame_beat_t;

  logic              clk;
  logic              rst_n;
  logic              cfg_psel;
  logic              cfg_penable;
  logic              cfg_pwrite;
  logic [CFG_AW-1:0] cfg_paddr;
  logic [CFG_DW-1:0] cfg_pwdata;
  logic [CFG_DW-1:0] cfg_prdata;
  logic              cfg_pready;

  bfr_in_if  in_chan ();
  bfr_out_if out_chan ();

  byte_frame_receiver_core u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .in_chan     (in_chan),
    .out_chan    (out_chan)
  );

  // receiver model state
  logic [BYTE_W-1:0] cfg_sof_byte = START_BYTE_RST;
  logic [BYTE_W-1:0] cfg_eof_byte = END_BYTE_RST;
  logic [LEN_W-1:0]  cfg_max_len  = MAX_LENGTH_RST;
  rx_phase_e         rx_phase     = HUNT_SOF;
  logic [POS_W-1:0]  rx_pos       = '0;
  logic [ID_W-1:0]   rx_ident     = '0;
  logic [LEN_W-1:0]  rx_length    = '0;
  logic [BYTE_W-1:0] payload_mem [PAYLOAD_CAP] = '{default: '0};
  logic              frame_ready  = 1'b0;

  frame_beat_t frame_beats_q [$];
  int          mismatches  = 0;
  int          sent_items  = 0;
  int          cycle_count = 0;
  logic        no_idle     = 1'b0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic int accept_limit();
    return (cfg_max_len < PAYLOAD_CAP) ? int'(cfg_max_len) : PAYLOAD_CAP;
  endfunction

  function automatic void model_rx_byte(input logic [BYTE_W-1:0] b);
    case (rx_phase)
      HUNT_SOF: begin
        if (b == cfg_sof_byte) begin
          rx_phase = GET_IDENT;
          rx_pos   = '0;
        end
      end
      GET_IDENT: begin
        if (rx_pos == 0) begin
          rx_ident[7:0] = b;
          rx_pos        = 1;
        end else begin
          rx_ident[15:8] = b;
          rx_phase       = GET_LENGTH;
          rx_pos         = '0;
        end
      end
      GET_LENGTH: begin
        // whole byte against the limit, not just the low bits kept
        if (int'(b) > accept_limit()) begin
          rx_phase = HUNT_SOF;
        end else begin
          rx_length = b[LEN_W-1:0];
          rx_pos    = '0;
          rx_phase  = (rx_length == 0) ? GET_CHECK : GET_PAYLOAD;
        end
      end
      GET_PAYLOAD: begin
        if (rx_pos < PAYLOAD_CAP) payload_mem[rx_pos] = b;
        rx_pos = rx_pos + 1'b1;
        if (rx_pos >= rx_length) begin
          rx_phase = GET_CHECK;
          rx_pos   = '0;
        end
      end
      GET_CHECK: begin
        rx_pos = rx_pos + 1'b1;
        if (rx_pos >= CHECK_BYTES) begin
          rx_phase = GET_EOF;
          rx_pos   = '0;
        end
      end
      GET_EOF: begin
        if (b == cfg_eof_byte) frame_ready = 1'b1;
        rx_phase = HUNT_SOF;
      end
      default: rx_phase = HUNT_SOF;
    endcase
  endfunction

  function automatic void model_fetch();
    frame_beat_t beat;
    int          n;
    beat = '0;
    if (!frame_ready) begin
      beat.last = 1'b1;
      frame_beats_q.push_back(beat);
      return;
    end
    frame_ready    = 1'b0;
    beat.available = 1'b1;
    beat.ident     = rx_ident;
    if (rx_length == 0) begin
      beat.last = 1'b1;
      frame_beats_q.push_back(beat);
      return;
    end
    n = (rx_length > MAX_RESULTS) ? MAX_RESULTS : int'(rx_length);
    for (int k = 0; k < n; k++) begin
      beat.length   = rx_length;
      beat.has_data = 1'b1;
      beat.data     = (k < PAYLOAD_CAP) ? payload_mem[k] : '0;
      beat.last     = (k == n - 1);
      frame_beats_q.push_back(beat);
    end
  endfunction

  function automatic void note_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("[%0d] %s", cycle_count, msg);
  endfunction

  always @(posedge clk) begin : beat_check
    frame_beat_t want;
    frame_beat_t got;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      got = '{out_chan.available, out_chan.frame_ident, out_chan.frame_length,
              out_chan.has_data, out_chan.data_byte, out_chan.last};
      if (frame_beats_q.size() == 0) begin
        note_mismatch($sformatf("unexpected beat avail=%0b id=%h len=%0d hd=%0b d=%h last=%0b",
                                got.available, got.ident, got.length, got.has_data,
                                got.data, got.last));
      end else begin
        want = frame_beats_q.pop_front();
        if (got.available !== want.available || got.ident !== want.ident ||
            got.length !== want.length || got.has_data !== want.has_data ||
            got.data !== want.data || got.last !== want.last) begin
          note_mismatch($sformatf({"beat mismatch exp avail=%0b id=%h len=%0d hd=%0b d=%h ",
                                   "last=%0b got avail=%0b id=%h len=%0d hd=%0b d=%h last=%0b"},
                                  want.available, want.ident, want.length, want.has_data,
                                  want.data, want.last, got.available, got.ident,
                                  got.length, got.has_data, got.data, got.last));
        end
      end
    end
  end

  // result side backpressure
  initial begin
    out_chan.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_chan.ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  task automatic send_item(input logic op, input logic [BYTE_W-1:0] b);
    @(negedge clk);
    while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      in_chan.valid <= 1'b0;
      @(negedge clk);
    end
    in_chan.valid   <= 1'b1;
    in_chan.op      <= op;
    in_chan.rx_byte <= b;
    do @(posedge clk); while (!in_chan.ready);
    sent_items++;
    if (op == OP_FETCH) model_fetch();
    else                model_rx_byte(b);
  endtask

  task automatic stop_sending();
    @(negedge clk);
    in_chan.valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (frame_beats_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [CFG_DW-1:0] val);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= val;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    case (idx)
      REG_START_BYTE: cfg_sof_byte = val[BYTE_W-1:0];
      REG_END_BYTE:   cfg_eof_byte = val[BYTE_W-1:0];
      REG_MAX_LENGTH: cfg_max_len  = val[LEN_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  task automatic apply_settings(input logic [BYTE_W-1:0] sof, input logic [BYTE_W-1:0] eof,
                                input logic [LEN_W-1:0] max_len);
    stop_sending();
    wait_drained();
    repeat (4) @(posedge clk);
    write_reg(REG_START_BYTE, CFG_DW'(sof));
    write_reg(REG_END_BYTE,   CFG_DW'(eof));
    write_reg(REG_MAX_LENGTH, CFG_DW'(max_len));
  endtask

  // Sends one frame from hunt state; stops after the length byte if it is too long.
  task automatic send_frame(input logic [ID_W-1:0] ident, input logic [BYTE_W-1:0] len_byte,
                            input logic good_eof);
    logic [BYTE_W-1:0] eof;
    while (rx_phase != HUNT_SOF) send_item(OP_BYTE, BYTE_W'($urandom));
    eof = good_eof ? cfg_eof_byte : cfg_eof_byte ^ BYTE_W'($urandom_range(255, 1));
    send_item(OP_BYTE, cfg_sof_byte);
    send_item(OP_BYTE, ident[7:0]);
    send_item(OP_BYTE, ident[15:8]);
    send_item(OP_BYTE, len_byte);
    if (int'(len_byte) > accept_limit()) return;
    repeat (int'(len_byte)) send_item(OP_BYTE, BYTE_W'($urandom));
    repeat (CHECK_BYTES) send_item(OP_BYTE, BYTE_W'($urandom));
    send_item(OP_BYTE, eof);
  endtask

  task automatic fetch_frame();
    send_item(OP_FETCH, BYTE_W'($urandom));
  endtask

  task automatic test_directed();
    fetch_frame();                          // nothing ready
    send_frame(16'hFFFF, 8'd0, 1'b1);       // zero length, sets ready
    send_frame(16'h0000, 8'd1, 1'b0);       // overwrites while ready, bad end keeps ready
    fetch_frame();
    send_frame(16'hA55A, 8'd65, 1'b1);      // low six bits legal, whole byte too long
    fetch_frame();
  endtask

  task automatic test_config_settings();
    apply_settings(8'h00, 8'hFF, 6'd0);
    send_frame(16'($urandom), 8'd0, 1'b1);
    fetch_frame();
    send_frame(16'($urandom), 8'd1, 1'b1);
    fetch_frame();

    apply_settings(8'hFF, 8'h00, 6'd32);
    send_frame(16'($urandom), 8'd32, 1'b1);
    fetch_frame();
    send_frame(16'($urandom), 8'd33, 1'b1);
    send_frame(16'($urandom), 8'd5, 1'b0);
    fetch_frame();

    repeat (2) begin
      apply_settings(BYTE_W'($urandom), BYTE_W'($urandom), LEN_W'($urandom_range(31, 1)));
      send_frame(16'($urandom), BYTE_W'($urandom_range(accept_limit())), 1'b1);
      fetch_frame();
      send_frame(16'($urandom), BYTE_W'(accept_limit() + 1), 1'b1);
      fetch_frame();
    end
  endtask

  task automatic test_random_traffic();
    int   goal;
    int   roll;
    int   lim;
    logic paused;
    apply_settings(START_BYTE_RST, END_BYTE_RST, LEN_W'($urandom_range(32, 4)));
    goal   = sent_items + RANDOM_ITEMS;
    paused = 1'b0;
    while (sent_items < goal) begin
      no_idle = (sent_items >= goal - 85) && (sent_items < goal - 35);
      if (!paused && sent_items >= goal - RANDOM_ITEMS / 2) begin
        stop_sending();
        wait_drained();
        paused = 1'b1;
      end
      lim  = accept_limit();
      roll = $urandom_range(99);
      if (roll < 60) begin
        // mostly short payloads, a few up to the limit
        send_frame(16'($urandom), BYTE_W'(($urandom_range(99) < 80) ?
                   $urandom_range((lim < 6) ? lim : 6) : $urandom_range(lim)), 1'b1);
        if ($urandom_range(99) < 75) fetch_frame();
      end else if (roll < 70) begin
        send_frame(16'($urandom), BYTE_W'($urandom_range((lim < 6) ? lim : 6)), 1'b0);
      end else if (roll < 76) begin
        send_frame(16'($urandom), BYTE_W'($urandom_range(255, lim + 1)), 1'b1);
      end else if (roll < 88) begin
        fetch_frame();
      end else begin
        repeat ($urandom_range(3, 1)) send_item(OP_BYTE, BYTE_W'($urandom));
      end
    end
    no_idle = 1'b0;
  endtask

  initial begin
    rst_n          = 1'b0;
    cfg_psel       = 1'b0;
    cfg_penable    = 1'b0;
    cfg_pwrite     = 1'b0;
    cfg_paddr      = '0;
    cfg_pwdata     = '0;
    in_chan.valid   = 1'b0;
    in_chan.op      = OP_BYTE;
    in_chan.rx_byte = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_config_settings();
    test_random_traffic();

    stop_sending();
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (frame_beats_q.size() != 0)
      note_mismatch($sformatf("%0d expected beats never arrived", frame_beats_q.size()));
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
